FILE: rtl/b64qc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b64qc_pkg;

  // Padding and special alphabet characters, and the sextet and byte masks
  localparam logic [7:0] PadChar   = 8'h3D;  // '='
  localparam logic [7:0] PlusChar  = 8'h2B;  // '+'
  localparam logic [7:0] SlashChar = 8'h2F;  // '/'
  localparam logic [5:0] SixMask   = 6'h3F;
  localparam logic [7:0] ByteMask  = 8'hFF;

  // Direction register codes
  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_e;

  // One input quantum
  typedef struct packed {
    logic [7:0] in_0;
    logic [7:0] in_1;
    logic [7:0] in_2;
    logic [7:0] in_3;
    logic [1:0] byte_count;
  } in_t;

  // One result quantum
  typedef struct packed {
    logic [7:0] out_0;
    logic [7:0] out_1;
    logic [7:0] out_2;
    logic [7:0] out_3;
    logic       bad_char;
  } out_t;

  // Result of mapping one character back to its sextet
  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } sextet_t;

  // Map a sextet to its alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] v8;
    logic [7:0] ch;
    v8 = {2'b00, v};
    if (v8 < 8'd26) begin
      ch = v8 + 8'd65;           // 'A'
    end else if (v8 < 8'd52) begin
      ch = v8 + 8'd71;           // 'a' - 26
    end else if (v8 < 8'd62) begin
      ch = v8 - 8'd4;            // '0' - 52
    end else if (v8 == 8'd62) begin
      ch = PlusChar;
    end else begin
      ch = SlashChar;
    end
    return ch;
  endfunction

  // Map a character to its sextet; pad is accepted as zero when allowed
  function automatic sextet_t dec_char(input logic [7:0] c, input logic pad_ok);
    sextet_t    r;
    logic [7:0] d;
    r = '0;
    d = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
      r.ok = 1'b1;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h47;             // 'a' - 26
      r.ok = 1'b1;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c + 8'd4;              // '0' maps to 52
      r.ok = 1'b1;
    end else if (c == PlusChar) begin
      d = 8'd62;
      r.ok = 1'b1;
    end else if (c == SlashChar) begin
      d = 8'd63;
      r.ok = 1'b1;
    end else if (pad_ok && c == PadChar) begin
      d = 8'd0;
      r.ok = 1'b1;
    end
    r.value = d[5:0] & SixMask;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/base64_quantum_codec.sv
// Datapath: an accepted quantum is held in the input register, goes through
//   one pass of encode or decode logic, and is captured in the result register.
// Throughput: one quantum per cycle; a stalled result stalls the input side
//   only once both the input and result registers hold an item.
// Reset: asynchronous, active low; clears both valid flags and sets the
//   direction register to encode.
`timescale 1ns / 1ps
`default_nettype none

module base64_quantum_codec (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire               cfg_wdata_i,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  b64qc_pkg::in_t    in_data_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output b64qc_pkg::out_t   out_data_o
);
  import b64qc_pkg::*;

  dir_e  dir_q;
  logic  in_valid_q;
  in_t   in_data_q;
  logic  res_valid_q;
  out_t  res_data_q, res_data_d;
  out_t  enc_res, dec_res;
  logic  res_ready;

  // Direction register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DIR_ENCODE;
    end else if (cfg_we_i) begin
      dir_q <= dir_e'(cfg_wdata_i);
    end
  end

  // Stage handshakes
  assign res_ready  = ~res_valid_q | out_ready_i;
  assign in_ready_o = ~in_valid_q | res_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
  end

  // Transcode
  b64qc_enc u_enc (
    .quantum_i (in_data_q),
    .result_o  (enc_res)
  );

  b64qc_dec u_dec (
    .quantum_i (in_data_q),
    .result_o  (dec_res)
  );

  assign res_data_d = (dir_q == DIR_DECODE) ? dec_res : enc_res;

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_ready) begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q && res_ready) begin
      res_data_q <= res_data_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_data_q;

  // Checks
  bad_char_zero_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_char |->
      out_data_o.out_0 == 8'h00 && out_data_o.out_1 == 8'h00 &&
      out_data_o.out_2 == 8'h00 && out_data_o.out_3 == 8'h00)
    else $error("bad_char result carries nonzero bytes");

  held_input_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !res_ready |=> in_valid_q && $stable(in_data_q))
    else $error("stalled input register lost its item");

  advance_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && res_ready |=> out_valid_o)
    else $error("item in input register did not reach the result register");

endmodule

`default_nettype wire

FILE: rtl/b64qc_enc.sv
`timescale 1ns / 1ps
`default_nettype none

module b64qc_enc (
  input  b64qc_pkg::in_t  quantum_i,
  output b64qc_pkg::out_t result_o
);
  import b64qc_pkg::*;

  logic [7:0]  b0, b1, b2;
  logic [23:0] word;

  // Zero the bytes past the count
  assign b0   = (quantum_i.byte_count >= 2'd1) ? quantum_i.in_0 : 8'h00;
  assign b1   = (quantum_i.byte_count >= 2'd2) ? quantum_i.in_1 : 8'h00;
  assign b2   = (quantum_i.byte_count == 2'd3) ? quantum_i.in_2 : 8'h00;
  assign word = {b0, b1, b2};

  // Look up the four characters and apply padding
  always_comb begin
    result_o          = '0;
    result_o.out_0    = enc_char(word[23:18]);
    result_o.out_1    = enc_char(word[17:12]);
    result_o.out_2    = enc_char(word[11:6]);
    result_o.out_3    = enc_char(word[5:0]);
    result_o.bad_char = 1'b0;
    case (quantum_i.byte_count)
      2'd1: begin
        result_o.out_2 = PadChar;
        result_o.out_3 = PadChar;
      end
      2'd2: begin
        result_o.out_3 = PadChar;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/b64qc_dec.sv
`timescale 1ns / 1ps
`default_nettype none

module b64qc_dec (
  input  b64qc_pkg::in_t  quantum_i,
  output b64qc_pkg::out_t result_o
);
  import b64qc_pkg::*;

  sextet_t     s0, s1, s2, s3;
  logic        all_ok;
  logic [23:0] word;

  // Map each character back; pad is legal in the last two places only
  assign s0     = dec_char(quantum_i.in_0, 1'b0);
  assign s1     = dec_char(quantum_i.in_1, 1'b0);
  assign s2     = dec_char(quantum_i.in_2, 1'b1);
  assign s3     = dec_char(quantum_i.in_3, 1'b1);
  assign all_ok = s0.ok & s1.ok & s2.ok & s3.ok;
  assign word   = {s0.value, s1.value, s2.value, s3.value};

  // Drop the bytes on an invalid character
  always_comb begin
    result_o          = '0;
    result_o.bad_char = ~all_ok;
    if (all_ok) begin
      result_o.out_0 = word[23:16] & ByteMask;
      result_o.out_1 = word[15:8] & ByteMask;
      result_o.out_2 = word[7:0] & ByteMask;
    end
  end

endmodule

`default_nettype wire

FILE: sim/base64_quantum_codec_test.sv
`timescale 1ns / 1ps

module base64_quantum_codec_test;
  import b64qc_pkg::*;

  // One row of the directed part: mode, quantum and, where obvious, the result
  typedef struct packed {
    dir_e mode;
    in_t  quantum;
    logic known;
    out_t want;
  } codec_case_t;

  logic clk_i     = 1'b0;
  logic rst_n     = 1'b0;
  logic cfg_we    = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_data_o;

  // Side information riding along with the quantum being offered
  logic typed_known = 1'b0;
  out_t typed_want  = '0;

  logic long_hold_due = 1'b0;
  logic quiet_tail    = 1'b0;
  dir_e mode_seen     = DIR_ENCODE;
  int   mismatches    = 0;

  out_t        expected_quanta[$];
  codec_case_t directed_cases[$];

  base64_quantum_codec u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  // Sextet to alphabet character
  function automatic logic [7:0] sextet_glyph(input logic [5:0] s);
    logic [7:0] s8;
    s8 = {2'b00, s};
    if (s8 < 8'd26) begin
      return 8'h41 + s8;
    end else if (s8 < 8'd52) begin
      return 8'h61 + (s8 - 8'd26);
    end else if (s8 < 8'd62) begin
      return 8'h30 + (s8 - 8'd52);
    end else if (s8 == 8'd62) begin
      return PlusChar;
    end
    return SlashChar;
  endfunction

  // Alphabet character back to its sextet; pad counts as zero only when allowed
  function automatic sextet_t glyph_sextet(input logic [7:0] c, input logic pad_ok);
    sextet_t r;
    r.ok    = 1'b1;
    r.value = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == PlusChar) begin
      r.value = 6'd62;
    end else if (c == SlashChar) begin
      r.value = 6'd63;
    end else if (!(pad_ok && c == PadChar)) begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // Work out the result quantum for one input quantum
  function automatic out_t codec_predict(input dir_e m, input in_t q);
    out_t        r;
    logic [23:0] w;
    logic [7:0]  g [4];
    sextet_t     s [4];
    logic        all_ok;
    r = '0;
    if (m == DIR_ENCODE) begin
      w = {(q.byte_count >= 2'd1) ? q.in_0 : 8'h00,
           (q.byte_count >= 2'd2) ? q.in_1 : 8'h00,
           (q.byte_count >= 2'd3) ? q.in_2 : 8'h00};
      r.out_0 = sextet_glyph(w[23:18]);
      r.out_1 = sextet_glyph(w[17:12]);
      r.out_2 = sextet_glyph(w[11:6]);
      r.out_3 = sextet_glyph(w[5:0]);
      // Pad the tail of a short quantum
      if (q.byte_count == 2'd1) begin
        r.out_2 = PadChar;
        r.out_3 = PadChar;
      end else if (q.byte_count == 2'd2) begin
        r.out_3 = PadChar;
      end
    end else begin
      g[0] = q.in_0;
      g[1] = q.in_1;
      g[2] = q.in_2;
      g[3] = q.in_3;
      all_ok = 1'b1;
      for (int i = 0; i < 4; i++) begin
        s[i] = glyph_sextet(g[i], i >= 2);
        all_ok = all_ok & s[i].ok;
      end
      if (all_ok) begin
        w = {s[0].value, s[1].value, s[2].value, s[3].value};
        r.out_0 = w[23:16];
        r.out_1 = w[15:8];
        r.out_2 = w[7:0];
      end else begin
        r.bad_char = 1'b1;
      end
    end
    return r;
  endfunction

  // Random plain bytes for encoding
  function automatic in_t random_plain();
    return in_t'({$urandom, 2'($urandom)});
  endfunction

  // Random characters for decoding: mostly well-formed, some padding, some noise
  function automatic in_t random_glyphs();
    logic [7:0] c [4];
    int         pick;
    for (int i = 0; i < 4; i++) begin
      c[i] = sextet_glyph(6'($urandom_range(0, 63)));
    end
    pick = $urandom_range(0, 19);
    if (pick < 3) begin
      c[3] = PadChar;
    end else if (pick < 5) begin
      c[2] = PadChar;
      c[3] = PadChar;
    end else if (pick == 5) begin
      c[2] = PadChar;
    end else if (pick < 9) begin
      c[$urandom_range(0, 3)] = 8'($urandom);
    end else if (pick == 9) begin
      for (int i = 0; i < 4; i++) begin
        c[i] = 8'($urandom);
      end
    end else if (pick == 10) begin
      c[$urandom_range(0, 1)] = PadChar;
    end
    return in_t'({c[0], c[1], c[2], c[3], 2'($urandom)});
  endfunction

  task automatic stage_case(input dir_e m, input logic [31:0] chars, input logic [1:0] cnt,
                            input logic known, input logic [31:0] want_chars,
                            input logic want_bad);
    codec_case_t row;
    row.mode    = m;
    row.quantum = in_t'({chars, cnt});
    row.known   = known;
    row.want    = out_t'({want_chars, want_bad});
    directed_cases.push_back(row);
  endtask

  // Offer one quantum after an optional idle burst and hold it until transfer
  task automatic offer_quantum(input in_t q, input logic known, input out_t want);
    int gap;
    gap = 0;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
    end
    repeat (gap) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid    <= 1'b1;
    in_data     <= q;
    typed_known <= known;
    typed_want  <= want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drain the block, then write the direction register
  task automatic settle_and_set_mode(input dir_e m);
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (expected_quanta.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random stalls, one long hold-off, none in the tail
  initial begin
    int   idle_left;
    logic long_hold_taken;
    idle_left       = 0;
    long_hold_taken = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_due && !long_hold_taken) begin
        long_hold_taken = 1'b1;
        idle_left       = 90;
      end else if (idle_left == 0 && !quiet_tail && $urandom_range(0, 5) == 0) begin
        idle_left = $urandom_range(1, 13);
      end
      if (idle_left > 0) begin
        out_ready <= 1'b0;
        idle_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Track the register, record accepted quanta and check every result transfer
  always @(posedge clk_i) begin
    out_t want;
    if (!rst_n) begin
      mode_seen = DIR_ENCODE;
    end else begin
      if (cfg_we) begin
        mode_seen = dir_e'(cfg_wdata);
      end
      if (in_valid && in_ready_o) begin
        expected_quanta.push_back(typed_known ? typed_want : codec_predict(mode_seen, in_data));
      end
      if (out_valid_o && out_ready) begin
        if (expected_quanta.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result %h at %0t", out_data_o, $realtime);
          end
        end else begin
          want = expected_quanta.pop_front();
          if (out_data_o.out_0 !== want.out_0 || out_data_o.out_1 !== want.out_1 ||
              out_data_o.out_2 !== want.out_2 || out_data_o.out_3 !== want.out_3 ||
              out_data_o.bad_char !== want.bad_char) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at %0t: want %h %h %h %h bad=%b, got %h %h %h %h bad=%b",
                       $realtime, want.out_0, want.out_1, want.out_2, want.out_3,
                       want.bad_char, out_data_o.out_0, out_data_o.out_1,
                       out_data_o.out_2, out_data_o.out_3, out_data_o.bad_char);
            end
          end
        end
      end
    end
  end

  // Stimulus: directed cases, then random phases alternating the direction
  initial begin
    dir_e drive_mode;
    dir_e m;
    drive_mode = DIR_ENCODE;

    // Encode: full quanta, extremes, short counts with junk past the count
    stage_case(DIR_ENCODE, "Man!", 2'd3, 1'b1, "TWFu", 1'b0);
    stage_case(DIR_ENCODE, 32'h00000000, 2'd3, 1'b1, "AAAA", 1'b0);
    stage_case(DIR_ENCODE, 32'hFFFFFFFF, 2'd3, 1'b1, "////", 1'b0);
    stage_case(DIR_ENCODE, 32'hFFFFFFFF, 2'd0, 1'b1, "AAAA", 1'b0);
    stage_case(DIR_ENCODE, "Man!", 2'd1, 1'b1, "TQ==", 1'b0);
    stage_case(DIR_ENCODE, "Man!", 2'd2, 1'b1, "TWE=", 1'b0);
    stage_case(DIR_ENCODE, 32'hFFA5A5A5, 2'd1, 1'b1, "/w==", 1'b0);
    stage_case(DIR_ENCODE, 32'hFFFF5A5A, 2'd2, 1'b1, "//8=", 1'b0);
    stage_case(DIR_ENCODE, 32'hFBEFBE00, 2'd3, 1'b1, "++++", 1'b0);
    stage_case(DIR_ENCODE, 32'h00108300, 2'd3, 1'b1, "ABCD", 1'b0);
    stage_case(DIR_ENCODE, 32'h12345678, 2'd3, 1'b0, 32'h0, 1'b0);
    // Decode: valid quanta, padding in the last two places, invalid characters
    stage_case(DIR_DECODE, "TWFu", 2'd0, 1'b1, 32'h4D616E00, 1'b0);
    stage_case(DIR_DECODE, "////", 2'd3, 1'b1, 32'hFFFFFF00, 1'b0);
    stage_case(DIR_DECODE, "AAAA", 2'd2, 1'b1, 32'h00000000, 1'b0);
    stage_case(DIR_DECODE, "TQ==", 2'd1, 1'b1, 32'h4D000000, 1'b0);
    stage_case(DIR_DECODE, "TWE=", 2'd3, 1'b1, 32'h4D610000, 1'b0);
    stage_case(DIR_DECODE, "TW=E", 2'd0, 1'b1, 32'h4D600400, 1'b0);
    stage_case(DIR_DECODE, "Zz9=", 2'd1, 1'b1, 32'h673F4000, 1'b0);
    stage_case(DIR_DECODE, "09+/", 2'd2, 1'b1, 32'hD3DFBF00, 1'b0);
    stage_case(DIR_DECODE, "=AAA", 2'd3, 1'b1, 32'h0, 1'b1);
    stage_case(DIR_DECODE, "A=AA", 2'd0, 1'b1, 32'h0, 1'b1);
    stage_case(DIR_DECODE, "A:A*", 2'd1, 1'b1, 32'h0, 1'b1);
    stage_case(DIR_DECODE, 32'h80414141, 2'd2, 1'b1, 32'h0, 1'b1);
    stage_case(DIR_DECODE, 32'h414141FF, 2'd3, 1'b1, 32'h0, 1'b1);
    stage_case(DIR_DECODE, 32'h405B607B, 2'd0, 1'b1, 32'h0, 1'b1);

    // Hold reset, then release it between edges
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    foreach (directed_cases[i]) begin
      if (directed_cases[i].mode != drive_mode) begin
        drive_mode = directed_cases[i].mode;
        settle_and_set_mode(drive_mode);
      end
      offer_quantum(directed_cases[i].quantum, directed_cases[i].known,
                    directed_cases[i].want);
    end

    for (int ph = 0; ph < 8; ph++) begin
      m = (ph % 2 == 0) ? DIR_DECODE : DIR_ENCODE;
      settle_and_set_mode(m);
      if (ph == 2) begin
        long_hold_due <= 1'b1;
      end
      if (ph == 7) begin
        quiet_tail <= 1'b1;
      end
      for (int k = 0; k < 144; k++) begin
        offer_quantum((m == DIR_ENCODE) ? random_plain() : random_glyphs(), 1'b0, '0);
      end
    end

    // Drop valid, drain, and allow for any stray result
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (expected_quanta.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    if (mismatches == 0 && expected_quanta.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: base64_quantum_codec.f
rtl/b64qc_pkg.sv
rtl/b64qc_enc.sv
rtl/b64qc_dec.sv
rtl/base64_quantum_codec.sv
sim/base64_quantum_codec_test.sv
